>>> rtl/bucketed_masked_prefix_match_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bucketed masked prefix match unit
// Shared property forms: same-cycle and next-cycle implication under reset.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_MASKED_PREFIX_MATCH_UNIT_DEFINES_SVH
`define BUCKETED_MASKED_PREFIX_MATCH_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BMPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BMPM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bmpm_pkg.sv
// ----------------------------------------------------------------------------
// bmpm_pkg
// Sizes, codes, shared types and mask table of the prefix match unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmpm_pkg;

	// Table geometry
	localparam int BUCKET_COUNT     = 64;
	localparam int BUCKET_DEPTH     = 32;
	localparam int LONGEST_PREFIX   = 16;
	localparam int SHORTEST_ENABLED = 4;

	// Field widths
	localparam int MODE_W    = 2;
	localparam int BKT_W     = 6;
	localparam int KEY_W     = 64;
	localparam int LEN_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 5;

	// Derived widths
	localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1);
	localparam int IDX_W       = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int WORDS       = BUCKET_COUNT * BUCKET_DEPTH;
	localparam int WORD_ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

	// Fill table command from the sequencer
	typedef struct packed {
		logic              rd;
		logic [BKT_W-1:0]  rd_bucket;
		logic              wr;
		logic [BKT_W-1:0]  wr_bucket;
		logic [FILL_W-1:0] wr_fill;
	} fill_cmd_t;

	// Don't-care mask per prefix length; short lengths mask everything
	function automatic logic [KEY_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] m;
		unique case (len)
			5'd4:    m = 64'hFFFF_FFFF_FFFF_FF0F;
			5'd5:    m = 64'hFFFF_FFFF_FFFF_7F00;
			5'd6:    m = 64'hFFFF_FFFF_FFFF_0300;
			5'd7:    m = 64'hFFFF_FFFF_FF1F_0000;
			5'd8:    m = 64'hFFFF_FFFF_FF00_0000;
			5'd9:    m = 64'hFFFF_FFFF_0700_0000;
			5'd10:   m = 64'hFFFF_FF3F_0000_0000;
			5'd11:   m = 64'hFFFF_FF01_0000_0000;
			5'd12:   m = 64'hFFFF_0F00_0000_0000;
			5'd13:   m = 64'hFF7F_0000_0000_0000;
			5'd14:   m = 64'hFF03_0000_0000_0000;
			5'd15:   m = 64'h1F00_0000_0000_0000;
			5'd16:   m = 64'h0000_0000_0000_0000;
			default: m = '1;
		endcase
		return m;
	endfunction

	// Midpoint of the half-open range [lo, hi_end), rounded down
	function automatic logic [IDX_W-1:0] mid_of(input logic [FILL_W-1:0] lo,
	                                            input logic [FILL_W-1:0] hi_end);
		logic [FILL_W:0] sum;
		sum = {1'b0, lo} + {1'b0, hi_end} - 1'b1;
		return sum[IDX_W:1];
	endfunction

endpackage

>>> rtl/bmpm_req_if.sv
// ----------------------------------------------------------------------------
// bmpm_req_if
// Request channel: mode, bucket and key with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmpm_req_if;
	logic                          valid;
	logic                          ready;
	logic [bmpm_pkg::MODE_W-1:0]   mode;
	logic [bmpm_pkg::BKT_W-1:0]    bucket_index;
	logic [bmpm_pkg::KEY_W-1:0]    key_value;

	modport source (output valid, mode, bucket_index, key_value, input ready);
	modport sink   (input valid, mode, bucket_index, key_value, output ready);
endinterface

>>> rtl/bmpm_rsp_if.sv
// ----------------------------------------------------------------------------
// bmpm_rsp_if
// Result channel: match length and full flag with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmpm_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bmpm_pkg::LEN_W-1:0]  match_length;
	logic                        bucket_full;

	modport source (output valid, match_length, bucket_full, input ready);
	modport sink   (input valid, match_length, bucket_full, output ready);
endinterface

>>> rtl/bucketed_masked_prefix_match_unit.sv
// ----------------------------------------------------------------------------
// bucketed_masked_prefix_match_unit
// Keeps 64 buckets of up to 32 64-bit words in append order and answers
// prefix lookups by binary search; one request is in work at a time. The
// single-port word memory gives a lookup one probe a cycle, up to 6 probes
// per length on a full bucket and up to 13 lengths. A new request is taken
// while the previous result still waits in the output register. Bucket
// fill counts read as zero from reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bucketed_masked_prefix_match_unit_defines.svh"

module bucketed_masked_prefix_match_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [bmpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmpm_pkg::CFG_W-1:0]         cfg_data,
	bmpm_req_if.sink                           req,
	bmpm_rsp_if.source                         rsp
);

	logic [bmpm_pkg::LEN_W-1:0]        min_length_q;
	logic [bmpm_pkg::LEN_W-1:0]        max_length_q;
	bmpm_pkg::fill_cmd_t               fill_cmd;
	logic [bmpm_pkg::FILL_W-1:0]       fill;
	logic                              ram_we;
	logic                              ram_re;
	logic [bmpm_pkg::WORD_ADDR_W-1:0]  ram_addr;
	logic [bmpm_pkg::KEY_W-1:0]        ram_wdata;
	logic [bmpm_pkg::KEY_W-1:0]        ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= bmpm_pkg::LEN_W'(bmpm_pkg::SHORTEST_ENABLED);
			max_length_q <= bmpm_pkg::LEN_W'(bmpm_pkg::LONGEST_PREFIX);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bmpm_pkg::CFG_MIN_LENGTH: min_length_q <= cfg_data;
				bmpm_pkg::CFG_MAX_LENGTH: max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bmpm_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fill_cmd),
		.fill   (fill)
	);

	bmpm_ram #(
		.WIDTH (bmpm_pkg::KEY_W),
		.DEPTH (bmpm_pkg::WORDS)
	) u_word_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	bmpm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.min_length (min_length_q),
		.max_length (max_length_q),
		.fill_cmd   (fill_cmd),
		.fill       (fill),
		.ram_we     (ram_we),
		.ram_re     (ram_re),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata)
	);

	// Checks
	`BMPM_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready, "request accepted while busy")
	`BMPM_ASSERT_IMP(a_append_bumps_fill, clk, arst_n, ram_we, fill_cmd.wr && (fill_cmd.wr_fill != '0), "word write without fill update")
	`BMPM_ASSERT_IMP(a_single_ram_access, clk, arst_n, ram_we, !ram_re, "word memory read and write together")
	`BMPM_ASSERT_IMP(a_match_in_range, clk, arst_n, rsp.valid && (rsp.match_length != '0), (rsp.match_length >= bmpm_pkg::LEN_W'(bmpm_pkg::SHORTEST_ENABLED)) && (rsp.match_length <= bmpm_pkg::LEN_W'(bmpm_pkg::LONGEST_PREFIX)) && !rsp.bucket_full, "match length out of range")

endmodule

>>> rtl/bmpm_ram.sv
// ----------------------------------------------------------------------------
// bmpm_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpm_ram #(
	parameter  int WIDTH  = 64,
	parameter  int DEPTH  = 2048,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_s1;

	// Write or read, never both
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata_s1 <= mem_q[addr];
		end
	end

	assign rdata = rdata_s1;

endmodule

>>> rtl/bmpm_fill.sv
// ----------------------------------------------------------------------------
// bmpm_fill
// Per-bucket fill counts in a small synchronous memory with valid bits, so
// that every bucket reads as empty after reset without a clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpm_fill (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bmpm_pkg::fill_cmd_t           cmd,
	output logic [bmpm_pkg::FILL_W-1:0]   fill
);

	logic [bmpm_pkg::FILL_W-1:0]     fill_mem_q [bmpm_pkg::BUCKET_COUNT];
	logic [bmpm_pkg::BUCKET_COUNT-1:0] valid_q;
	logic [bmpm_pkg::FILL_W-1:0]     rd_data_s1;
	logic                            rd_valid_s1;

	// Count storage
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			fill_mem_q[cmd.wr_bucket] <= cmd.wr_fill;
		end
		if (cmd.rd) begin
			rd_data_s1 <= fill_mem_q[cmd.rd_bucket];
		end
	end

	// Written-since-reset marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.wr) begin
				valid_q[cmd.wr_bucket] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_valid_s1 <= valid_q[cmd.rd_bucket];
			end
		end
	end

	// Unwritten bucket reads as empty
	assign fill = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

>>> rtl/bmpm_seq.sv
// ----------------------------------------------------------------------------
// bmpm_seq
// Request sequencer: takes one request, reads its bucket fill, appends or
// clears, or binary-searches the word memory for each prefix length in turn
// until one matches, then hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmpm_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	bmpm_req_if.sink                            req,
	bmpm_rsp_if.source                          rsp,
	input  logic [bmpm_pkg::LEN_W-1:0]          min_length,
	input  logic [bmpm_pkg::LEN_W-1:0]          max_length,
	output bmpm_pkg::fill_cmd_t                 fill_cmd,
	input  logic [bmpm_pkg::FILL_W-1:0]         fill,
	output logic                                ram_we,
	output logic                                ram_re,
	output logic [bmpm_pkg::WORD_ADDR_W-1:0]    ram_addr,
	output logic [bmpm_pkg::KEY_W-1:0]          ram_wdata,
	input  logic [bmpm_pkg::KEY_W-1:0]          ram_rdata
);

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FILL  = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                          state_q, state_d;
	logic [bmpm_pkg::MODE_W-1:0]         mode_q;
	logic [bmpm_pkg::BKT_W-1:0]          bucket_q;
	logic [bmpm_pkg::KEY_W-1:0]          key_q;
	logic [bmpm_pkg::WORD_ADDR_W-1:0]    base_q;
	logic [bmpm_pkg::LEN_W-1:0]          len_q, len_d;
	logic [bmpm_pkg::LEN_W-1:0]          len_hi_q, len_hi_d;
	logic [bmpm_pkg::FILL_W-1:0]         fill_q, fill_d;
	logic [bmpm_pkg::FILL_W-1:0]         lo_q, lo_d;
	logic [bmpm_pkg::FILL_W-1:0]         span_end_q, span_end_d;
	logic [bmpm_pkg::IDX_W-1:0]          mid_q, mid_d;
	logic [bmpm_pkg::LEN_W-1:0]          res_match_q, res_match_d;
	logic                                res_full_q, res_full_d;
	logic                                out_valid_q;
	logic [bmpm_pkg::LEN_W-1:0]          out_match_q;
	logic                                out_full_q;

	logic                                accept;
	logic                                load_out;
	logic                                bucket_ok;
	logic [bmpm_pkg::LEN_W-1:0]          lo_len, hi_len;
	logic [bmpm_pkg::KEY_W-1:0]          target;
	logic                                probe_eq, probe_lt;
	logic [bmpm_pkg::FILL_W-1:0]         next_lo, next_end;
	logic [bmpm_pkg::IDX_W-1:0]          ram_idx;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// Effective length range from configuration
	assign lo_len = (min_length < bmpm_pkg::LEN_W'(bmpm_pkg::SHORTEST_ENABLED))
		? bmpm_pkg::LEN_W'(bmpm_pkg::SHORTEST_ENABLED) : min_length;
	assign hi_len = (max_length > bmpm_pkg::LEN_W'(bmpm_pkg::LONGEST_PREFIX))
		? bmpm_pkg::LEN_W'(bmpm_pkg::LONGEST_PREFIX) : max_length;

	assign bucket_ok = (32'(bucket_q) < bmpm_pkg::BUCKET_COUNT);

	// Probe compare against the masked key
	assign target   = key_q | bmpm_pkg::len_mask(len_q);
	assign probe_eq = (ram_rdata == target);
	assign probe_lt = (ram_rdata < target);
	assign next_lo  = probe_lt ? (bmpm_pkg::FILL_W'(mid_q) + 1'b1) : lo_q;
	assign next_end = probe_lt ? span_end_q : bmpm_pkg::FILL_W'(mid_q);

	// Next-state and memory commands
	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		len_hi_d    = len_hi_q;
		fill_d      = fill_q;
		lo_d        = lo_q;
		span_end_d  = span_end_q;
		mid_d       = mid_q;
		res_match_d = res_match_q;
		res_full_d  = res_full_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_idx     = mid_q;
		load_out    = 1'b0;
		fill_cmd           = '0;
		fill_cmd.rd        = accept;
		fill_cmd.rd_bucket = req.bucket_index;
		fill_cmd.wr_bucket = bucket_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d     = ST_FILL;
					res_match_d = '0;
					res_full_d  = 1'b0;
				end
			end
			ST_FILL: begin
				state_d = ST_DONE;
				if (bucket_ok) begin
					case (mode_q)
						bmpm_pkg::MODE_CLEAR: begin
							fill_cmd.wr      = 1'b1;
							fill_cmd.wr_fill = '0;
						end
						bmpm_pkg::MODE_APPEND: begin
							if (fill >= bmpm_pkg::FILL_W'(bmpm_pkg::BUCKET_DEPTH)) begin
								res_full_d = 1'b1;
							end else begin
								ram_we           = 1'b1;
								ram_idx          = fill[bmpm_pkg::IDX_W-1:0];
								fill_cmd.wr      = 1'b1;
								fill_cmd.wr_fill = fill + 1'b1;
							end
						end
						bmpm_pkg::MODE_LOOKUP: begin
							if ((fill != '0) && (lo_len <= hi_len)) begin
								len_d      = lo_len;
								len_hi_d   = hi_len;
								fill_d     = fill;
								lo_d       = '0;
								span_end_d = fill;
								mid_d      = bmpm_pkg::mid_of('0, fill);
								ram_re     = 1'b1;
								ram_idx    = mid_d;
								state_d    = ST_PROBE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_PROBE: begin
				if (probe_eq) begin
					res_match_d = len_q;
					state_d     = ST_DONE;
				end else if (next_lo < next_end) begin
					// Narrow the range and probe again
					lo_d       = next_lo;
					span_end_d = next_end;
					mid_d      = bmpm_pkg::mid_of(next_lo, next_end);
					ram_re     = 1'b1;
					ram_idx    = mid_d;
				end else if (len_q == len_hi_q) begin
					state_d = ST_DONE;
				end else begin
					// Next prefix length, whole bucket again
					len_d      = len_q + 1'b1;
					lo_d       = '0;
					span_end_d = fill_q;
					mid_d      = bmpm_pkg::mid_of('0, fill_q);
					ram_re     = 1'b1;
					ram_idx    = mid_d;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign ram_addr  = base_q + bmpm_pkg::WORD_ADDR_W'(ram_idx);
	assign ram_wdata = key_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, search and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= req.mode;
			bucket_q <= req.bucket_index;
			key_q    <= req.key_value;
			base_q   <= bmpm_pkg::WORD_ADDR_W'(req.bucket_index * bmpm_pkg::BUCKET_DEPTH);
		end
		len_q       <= len_d;
		len_hi_q    <= len_hi_d;
		fill_q      <= fill_d;
		lo_q        <= lo_d;
		span_end_q  <= span_end_d;
		mid_q       <= mid_d;
		res_match_q <= res_match_d;
		res_full_q  <= res_full_d;
		if (load_out) begin
			out_match_q <= res_match_q;
			out_full_q  <= res_full_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.match_length = out_match_q;
	assign rsp.bucket_full  = out_full_q;

endmodule

>>> dv/bucketed_masked_prefix_match_unit_test.sv
// ----------------------------------------------------------------------------
// bucketed_masked_prefix_match_unit_test
// Drives lookup, append, clear and unused-mode requests into the prefix
// match unit under random idling on both channels. Every accepted request is
// run through a local prediction of the bucket table and the masked binary
// search. Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bucketed_masked_prefix_match_unit_test;

	// Mode value the unit must ignore
	localparam logic [bmpm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	// Cycles without any handshake before the run is abandoned
	localparam int STALL_LIMIT = 4000;
	// Long receiver hold-off that backs the unit up
	localparam int LONG_HOLD = 400;
	// Drain time after the last result, longer than a worst-case lookup
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [bmpm_pkg::LEN_W-1:0] match_length;
		logic                       bucket_full;
	} prefix_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                           cfg_wr_en;
	logic [bmpm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bmpm_pkg::CFG_W-1:0]     cfg_data;

	bmpm_req_if req_ch ();
	bmpm_rsp_if rsp_ch ();

	bucketed_masked_prefix_match_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	// Local copy of the table and the length window
	logic [bmpm_pkg::KEY_W-1:0] stored_words [bmpm_pkg::BUCKET_COUNT][bmpm_pkg::BUCKET_DEPTH];
	int unsigned                bucket_level [bmpm_pkg::BUCKET_COUNT];
	logic [bmpm_pkg::CFG_W-1:0] min_len_reg;
	logic [bmpm_pkg::CFG_W-1:0] max_len_reg;

	prefix_result_t expected_matches [$];
	int  error_count = 0;
	int  requests_sent = 0;
	int  result_hold_cycles = 0;
	bit  send_gaps_on = 1'b1;
	bit  recv_gaps_on = 1'b1;

	function automatic logic [bmpm_pkg::KEY_W-1:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic int draw_idle(input bit enabled);
		return enabled ? int'($urandom_range(0, 15)) : 0;
	endfunction

	// Don't-care bits per prefix length; lengths below four mask everything
	function automatic logic [bmpm_pkg::KEY_W-1:0] dont_care_mask(input int len);
		case (len)
			4:       return 64'hFFFF_FFFF_FFFF_FF0F;
			5:       return 64'hFFFF_FFFF_FFFF_7F00;
			6:       return 64'hFFFF_FFFF_FFFF_0300;
			7:       return 64'hFFFF_FFFF_FF1F_0000;
			8:       return 64'hFFFF_FFFF_FF00_0000;
			9:       return 64'hFFFF_FFFF_0700_0000;
			10:      return 64'hFFFF_FF3F_0000_0000;
			11:      return 64'hFFFF_FF01_0000_0000;
			12:      return 64'hFFFF_0F00_0000_0000;
			13:      return 64'hFF7F_0000_0000_0000;
			14:      return 64'hFF03_0000_0000_0000;
			15:      return 64'h1F00_0000_0000_0000;
			16:      return 64'h0000_0000_0000_0000;
			default: return '1;
		endcase
	endfunction

	// Membership by binary search over the filled part of a bucket
	function automatic bit bucket_contains(input int b, input logic [bmpm_pkg::KEY_W-1:0] v);
		int lo, hi, mid;
		lo = 0;
		hi = int'(bucket_level[b]) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (stored_words[b][mid] == v)
				return 1'b1;
			if (stored_words[b][mid] < v)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return 1'b0;
	endfunction

	// Expected result of one request; updates the local table
	function automatic prefix_result_t predict_match(input logic [bmpm_pkg::MODE_W-1:0] m,
	                                                 input logic [bmpm_pkg::BKT_W-1:0] b,
	                                                 input logic [bmpm_pkg::KEY_W-1:0] k);
		prefix_result_t r;
		int lo_len, hi_len, l;
		r = '0;
		case (m)
			bmpm_pkg::MODE_LOOKUP: begin
				lo_len = (min_len_reg < bmpm_pkg::SHORTEST_ENABLED)
					? bmpm_pkg::SHORTEST_ENABLED : int'(min_len_reg);
				hi_len = (max_len_reg > bmpm_pkg::LONGEST_PREFIX)
					? bmpm_pkg::LONGEST_PREFIX : int'(max_len_reg);
				if (bucket_level[b] != 0)
					for (l = lo_len; l <= hi_len; l++)
						if (r.match_length == 0 && bucket_contains(b, k | dont_care_mask(l)))
							r.match_length = bmpm_pkg::LEN_W'(l);
			end
			bmpm_pkg::MODE_APPEND: begin
				if (bucket_level[b] >= bmpm_pkg::BUCKET_DEPTH) begin
					r.bucket_full = 1'b1;
				end else begin
					stored_words[b][bucket_level[b]] = k;
					bucket_level[b]++;
				end
			end
			bmpm_pkg::MODE_CLEAR: bucket_level[b] = 0;
			default: ;
		endcase
		return r;
	endfunction

	// Offer one request after a random gap and wait for it to be taken
	task automatic send_request(input logic [bmpm_pkg::MODE_W-1:0] m,
	                            input logic [bmpm_pkg::BKT_W-1:0] b,
	                            input logic [bmpm_pkg::KEY_W-1:0] k);
		int gap;
		gap = draw_idle(send_gaps_on);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= m;
		req_ch.bucket_index <= b;
		req_ch.key_value    <= k;
		do @(posedge clk); while (!req_ch.ready);
		expected_matches.push_back(predict_match(m, b, k));
		requests_sent++;
	endtask

	// Stop offering and let every outstanding result come back
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_matches.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// Both registers written on back-to-back cycles while the unit is idle
	task automatic set_length_window(input logic [bmpm_pkg::CFG_W-1:0] lo,
	                                 input logic [bmpm_pkg::CFG_W-1:0] hi);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= bmpm_pkg::CFG_MIN_LENGTH;
		cfg_data  <= lo;
		@(posedge clk);
		min_len_reg = lo;
		cfg_index <= bmpm_pkg::CFG_MAX_LENGTH;
		cfg_data  <= hi;
		@(posedge clk);
		max_len_reg = hi;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Fill one bucket with masked words, then look up keys derived from them
	task automatic run_bucket_session(input int lookups);
		logic [bmpm_pkg::KEY_W-1:0] words [12];
		logic [bmpm_pkg::KEY_W-1:0] held, key, m;
		logic [bmpm_pkg::BKT_W-1:0] b;
		int count, i, j, pick;
		b = bmpm_pkg::BKT_W'($urandom_range(0, bmpm_pkg::BUCKET_COUNT - 1));
		count = int'($urandom_range(1, 12));
		for (i = 0; i < count; i++)
			words[i] = random_word() | dont_care_mask(int'($urandom_range(4, 16)));
		// mostly ascending; the odd session leaves the order as drawn
		if ($urandom_range(0, 7) != 0)
			for (i = 1; i < count; i++) begin
				held = words[i];
				j = i - 1;
				while (j >= 0 && words[j] > held) begin
					words[j + 1] = words[j];
					j--;
				end
				words[j + 1] = held;
			end
		if ($urandom_range(0, 5) != 0)
			send_request(bmpm_pkg::MODE_CLEAR, b, random_word());
		for (i = 0; i < count; i++)
			send_request(bmpm_pkg::MODE_APPEND, b, words[i]);
		for (i = 0; i < lookups; i++) begin
			pick = int'($urandom_range(0, count - 1));
			m = dont_care_mask(int'($urandom_range(4, 16)));
			case ($urandom_range(0, 5))
				0:       key = random_word();
				1:       key = words[pick];
				default: key = (words[pick] & ~m) | (random_word() & m);
			endcase
			send_request(bmpm_pkg::MODE_LOOKUP, b, key);
		end
	endtask

	task automatic send_noise_request();
		send_request(bmpm_pkg::MODE_W'($urandom_range(0, 3)),
		             bmpm_pkg::BKT_W'($urandom_range(0, bmpm_pkg::BUCKET_COUNT - 1)),
		             random_word());
	endtask

	// Field extremes, every mode, empty buckets and each length boundary
	task automatic test_directed();
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd0, 64'h0);
		send_request(bmpm_pkg::MODE_APPEND, 6'd0, 64'h0);
		send_request(bmpm_pkg::MODE_APPEND, 6'd0, '1);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd0, 64'h0);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd0, 64'hF0);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd0, 64'h0123_4567_89AB_CDEF);
		send_request(bmpm_pkg::MODE_APPEND, 6'd63, 64'h1F00_0000_0000_0000);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd63, 64'h0);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd63, 64'h1F00_0000_0000_0000);
		send_request(MODE_UNUSED, 6'd63, '1);
		send_request(MODE_UNUSED, 6'd0, 64'h0);
		send_request(bmpm_pkg::MODE_CLEAR, 6'd0, '1);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd0, '1);
		send_request(bmpm_pkg::MODE_APPEND, 6'd0, '1);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd0, 64'h0);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd0, 64'hF0);
		send_request(bmpm_pkg::MODE_CLEAR, 6'd63, 64'h0);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd63, 64'h0);
		send_request(bmpm_pkg::MODE_APPEND, 6'd17, 64'hFFFF_FFFF_0700_0000);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd17, 64'h0);
		send_request(bmpm_pkg::MODE_CLEAR, 6'd17, 64'h0);
		send_request(bmpm_pkg::MODE_CLEAR, 6'd17, 64'h0);
	endtask

	// Fill a bucket to the brim, overflow it, search its ends, then empty it and refill one word
	task automatic test_full_bucket();
		logic [bmpm_pkg::KEY_W-1:0] words [bmpm_pkg::BUCKET_DEPTH];
		logic [bmpm_pkg::KEY_W-1:0] fresh;
		int i;
		for (i = 0; i < bmpm_pkg::BUCKET_DEPTH; i++) begin
			fresh = random_word();
			words[i] = {i[5:0], fresh[57:0]};
		end
		send_request(bmpm_pkg::MODE_CLEAR, 6'd33, 64'h0);
		for (i = 0; i < bmpm_pkg::BUCKET_DEPTH; i++)
			send_request(bmpm_pkg::MODE_APPEND, 6'd33, words[i]);
		send_request(bmpm_pkg::MODE_APPEND, 6'd33, '1);
		send_request(bmpm_pkg::MODE_APPEND, 6'd33, 64'h0);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd33, words[0]);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd33, words[bmpm_pkg::BUCKET_DEPTH / 2]);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd33, words[bmpm_pkg::BUCKET_DEPTH - 1]);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd33, random_word());
		send_request(bmpm_pkg::MODE_CLEAR, 6'd33, 64'h0);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd33, words[0]);
		send_request(bmpm_pkg::MODE_APPEND, 6'd33, words[3]);
		send_request(bmpm_pkg::MODE_LOOKUP, 6'd33, words[3]);
	endtask

	// Sessions under a spread of length windows, extremes and empty ones too
	task automatic test_length_windows();
		logic [bmpm_pkg::CFG_W-1:0] lows  [8] = '{5'd0, 5'd16, 5'd4, 5'd10, 5'd31, 5'd3,
		                                          5'd7, 5'd5};
		logic [bmpm_pkg::CFG_W-1:0] highs [8] = '{5'd31, 5'd16, 5'd4, 5'd7, 5'd0, 5'd17,
		                                          5'd12, 5'd5};
		int s, start;
		for (s = 0; s < 8; s++) begin
			set_length_window(lows[s], highs[s]);
			start = requests_sent;
			while (requests_sent < start + 40)
				run_bucket_session(int'($urandom_range(2, 8)));
		end
		set_length_window(5'd4, 5'd16);
	endtask

	// Bulk traffic: mostly well-formed sessions, some noise, varying idling
	task automatic test_random_traffic();
		int start;
		start = requests_sent;
		while (requests_sent < start + 160) begin
			send_gaps_on = $urandom_range(0, 2) != 0;
			recv_gaps_on = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 4)) send_noise_request();
			else
				run_bucket_session(int'($urandom_range(1, 10)));
		end
		send_gaps_on = 1'b1;
		recv_gaps_on = 1'b1;
	endtask

	// Receiver holds off while requests keep coming, so the input stalls
	task automatic test_result_backpressure();
		send_gaps_on = 1'b0;
		result_hold_cycles = LONG_HOLD;
		run_bucket_session(12);
		send_gaps_on = 1'b1;
	endtask

	// Sender goes quiet until everything is back, several times over
	task automatic test_sender_pause();
		repeat (4) begin
			run_bucket_session(int'($urandom_range(1, 4)));
			wait_for_results();
		end
	endtask

	// Result channel ready with random stalls and the occasional long hold
	initial begin : result_sink
		int stall, held;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (result_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				for (held = 0; held < result_hold_cycles; held++)
					@(posedge clk);
				result_hold_cycles = 0;
			end
			stall = draw_idle(recv_gaps_on);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Compare each result taken with the oldest prediction
	always @(posedge clk) begin
		prefix_result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_matches.size() == 0) begin
				$error("result with no request outstanding: match_length %0d bucket_full %0d",
				       rsp_ch.match_length, rsp_ch.bucket_full);
				error_count++;
			end else begin
				exp_r = expected_matches.pop_front();
				if (rsp_ch.match_length !== exp_r.match_length) begin
					$error("match_length: expected %0d, actual %0d",
					       exp_r.match_length, rsp_ch.match_length);
					error_count++;
				end
				if (rsp_ch.bucket_full !== exp_r.bucket_full) begin
					$error("bucket_full: expected %0d, actual %0d",
					       exp_r.bucket_full, rsp_ch.bucket_full);
					error_count++;
				end
			end
		end
	end

	// Abandon the run if neither channel moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int b;
		arst_n              <= 1'b0;
		cfg_wr_en           <= 1'b0;
		cfg_index           <= bmpm_pkg::CFG_MIN_LENGTH;
		cfg_data            <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.mode         <= bmpm_pkg::MODE_LOOKUP;
		req_ch.bucket_index <= '0;
		req_ch.key_value    <= '0;
		for (b = 0; b < bmpm_pkg::BUCKET_COUNT; b++)
			bucket_level[b] = 0;
		min_len_reg = 5'd4;
		max_len_reg = 5'd16;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_bucket();
		test_length_windows();
		test_random_traffic();
		test_result_backpressure();
		test_sender_pause();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_matches.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
